/* rtl/rcs_pkg.sv */
// Shared types, codes and constants of the ring cadence sequencer.
package rcs_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;

   localparam int NOW_W      = 32;
   localparam int DELAY_W    = 12;
   localparam int DUR_W      = 16;
   localparam int RINGS_W    = 4;
   localparam int PCT_W      = 7;
   localparam int FRAC_W     = 16;
   localparam int WAIT_W     = 22;
   localparam int LO_W       = 13;
   localparam int CUT_PROD_W = DUR_W + PCT_W;
   localparam int RECIP_W    = 24;
   localparam int RECIP_SH   = 30;
   localparam int CUT_W      = 17;
   localparam int WPROD_W    = WAIT_W + FRAC_W;

   localparam int MS_PER_S          = 1000;
   localparam int MIN_WAIT_MS       = 5000;
   localparam int DONE_PAUSE_MS     = 1000;
   localparam int RECIP_100         = 10737419;
   localparam int MAX_DELAY_DEFAULT = 60;
   localparam int RING_ON_DEFAULT   = 2000;
   localparam int RING_GAP_DEFAULT  = 4000;

   localparam logic [1:0] REG_MAX_DELAY = 2'd0;
   localparam logic [1:0] REG_RING_ON   = 2'd1;
   localparam logic [1:0] REG_RING_GAP  = 2'd2;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_RING_ON  = 3'd1,
      PH_SILENT   = 3'd2,
      PH_DONE     = 3'd3,
      PH_WAITING  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [FRAC_W-1:0]  draw_fraction;
      logic [PCT_W-1:0]   draw_percent;
      logic               draw_coin;
      logic [RINGS_W-1:0] draw_rings;
      logic               given_cut;
      logic [RINGS_W-1:0] given_rings;
      logic               may_start;
      logic [NOW_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [RINGS_W-1:0] ring_number;
      logic               busy_res;
      logic               ringing;
      phase_type          phase;
      logic               relay_on;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic calc1;
      logic calc2;
      logic commit;
   } cmd_type;

endpackage

/* rtl/ring_cadence_sequencer_top.sv */
// Top level of the ring cadence sequencer: request and response streams and register port.
//
// Each request (a tick, an explicit call start or a stop, with the current millisecond
// time) produces exactly one response giving the relay drive, the cadence phase and the
// ring number after the update. From acceptance to its response a request is captured,
// passes through two multiplier stages that scale the random wait and the shortened final
// ring, and then updates the cadence state. The next request is accepted once the previous
// one has been committed; a response that has not yet been taken only holds up the commit of
// the following request. Registers must be written while no request is in flight.
module ring_cadence_sequencer_top #(
   parameter int TIME_WIDTH = rcs_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // now_ms[31:0], may_start[32], given_rings[36:33], given_cut[37], draw_rings[41:38],
   // draw_coin[42], draw_percent[49:43], draw_fraction[65:50], zero padding above.
   input  logic [rcs_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0].
   input  logic [rcs_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // relay_on[0], phase[3:1], ringing[4], busy_res[5], ring_number[9:6], zero padding above.
   output logic [rcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rcs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rcs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rcs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   rcs_pkg::cmd_type cmd;
   rcs_pkg::req_type req_data;
   rcs_pkg::rsp_type rsp_data;
   logic             csr_wr_en;

   assign csr_pready = 1'b1;
   assign csr_wr_en  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_data   = req_tdata[$bits(rcs_pkg::req_type)-1:0];
   assign rsp_tdata  = rcs_pkg::RSP_DATA_W'(rsp_data);

   rcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rcs_datapath #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_op    (req_tuser),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_paddr[3:2]),
      .csr_wdata (csr_pwdata),
      .csr_rdata (csr_prdata),
      .rsp_data  (rsp_data)
   );

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("A request was accepted while another was still in flight.");

   a_relay_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_data.relay_on == (rsp_data.phase == rcs_pkg::PH_RING_ON)))
      else $error("Relay drive disagrees with the ring-on phase.");

   a_busy_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_data.busy_res == ((rsp_data.phase != rcs_pkg::PH_IDLE)
                                         && (rsp_data.phase != rcs_pkg::PH_WAITING))))
      else $error("Busy flag disagrees with the phase.");

endmodule

/* rtl/rcs_ctrl.sv */
// Controller state machine that sequences one request through the datapath.
module rcs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output rcs_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC1,
      S_CALC2,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.capture = req_tvalid && (state_ff == S_IDLE);
      cmd.calc1   = (state_ff == S_CALC1);
      cmd.calc2   = (state_ff == S_CALC2);
      cmd.commit  = (state_ff == S_COMMIT) && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CALC1;
            end
         end
         S_CALC1: state_in = S_CALC2;
         S_CALC2: state_in = S_COMMIT;
         S_COMMIT: begin
            if (slot_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/rcs_datapath.sv */
// Datapath: cadence state, configuration registers, wait and cut-length arithmetic.
module rcs_datapath #(
   parameter int TIME_WIDTH = rcs_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rcs_pkg::cmd_type              cmd,
   input  logic [rcs_pkg::REQ_USER_W-1:0] req_op,
   input  rcs_pkg::req_type              req_data,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [rcs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [rcs_pkg::CSR_DATA_W-1:0] csr_rdata,
   output rcs_pkg::rsp_type              rsp_data
);

   localparam int CMP_W = (TIME_WIDTH > rcs_pkg::WAIT_W) ? TIME_WIDTH : rcs_pkg::WAIT_W;

   // Configuration registers.
   logic [rcs_pkg::DELAY_W-1:0] max_delay_ff;
   logic [rcs_pkg::DUR_W-1:0]   ring_on_ff, ring_on_in;
   logic [rcs_pkg::DUR_W-1:0]   ring_gap_ff, ring_gap_in;

   // Captured request.
   logic [rcs_pkg::REQ_USER_W-1:0] op_ff;
   rcs_pkg::req_type               req_ff;

   // Arithmetic pipeline.
   logic [rcs_pkg::WAIT_W-1:0]     hi_ff;
   logic [rcs_pkg::CUT_PROD_W-1:0] cut_prod_ff;
   logic [rcs_pkg::LO_W-1:0]       lo_ff;
   logic [rcs_pkg::WPROD_W-1:0]    wait_prod_ff;
   logic [rcs_pkg::CUT_W-1:0]      cut_dur_ff;

   logic [rcs_pkg::WAIT_W-1:0]     lo_full;
   logic [rcs_pkg::WAIT_W-1:0]     span;
   logic [rcs_pkg::CUT_PROD_W+rcs_pkg::RECIP_W-1:0] cut_quot;

   // Cadence state.
   rcs_pkg::phase_type          phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]       last_ff, last_in;
   logic [rcs_pkg::WAIT_W-1:0]  wait_ff, wait_in;
   logic [rcs_pkg::RINGS_W-1:0] index_ff, index_in;
   logic [rcs_pkg::RINGS_W-1:0] total_ff, total_in;
   logic                        cut_ff, cut_in;
   logic                        relay_ff, relay_in;
   rcs_pkg::rsp_type            out_ff, out_in;

   logic [TIME_WIDTH-1:0]       now_t;
   logic [TIME_WIDTH-1:0]       elapsed;
   logic [CMP_W-1:0]            el;
   logic [CMP_W-1:0]            dur;
   logic [rcs_pkg::WAIT_W-1:0]  wait_full;

   assign lo_full  = (hi_ff <= rcs_pkg::WAIT_W'(rcs_pkg::MIN_WAIT_MS))
                     ? (hi_ff >> 1) : rcs_pkg::WAIT_W'(rcs_pkg::MIN_WAIT_MS);
   assign span     = hi_ff - lo_full + rcs_pkg::WAIT_W'(1);
   assign cut_quot = (rcs_pkg::CUT_PROD_W+rcs_pkg::RECIP_W)'(cut_prod_ff)
                     * (rcs_pkg::CUT_PROD_W+rcs_pkg::RECIP_W)'(rcs_pkg::RECIP_100);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         req_ff <= req_data;
      end
      if (cmd.calc1) begin
         hi_ff       <= rcs_pkg::WAIT_W'(max_delay_ff) * rcs_pkg::WAIT_W'(rcs_pkg::MS_PER_S);
         cut_prod_ff <= rcs_pkg::CUT_PROD_W'(ring_on_ff)
                        * rcs_pkg::CUT_PROD_W'(req_ff.draw_percent);
      end
      if (cmd.calc2) begin
         lo_ff        <= lo_full[rcs_pkg::LO_W-1:0];
         wait_prod_ff <= rcs_pkg::WPROD_W'(span) * rcs_pkg::WPROD_W'(req_ff.draw_fraction);
         cut_dur_ff   <= cut_quot[rcs_pkg::RECIP_SH +: rcs_pkg::CUT_W];
      end
      if (cmd.commit) begin
         out_ff <= out_in;
      end
   end

   assign now_t     = TIME_WIDTH'(req_ff.now_ms);
   assign elapsed   = now_t - last_ff;
   assign el        = CMP_W'(elapsed);
   assign wait_full = rcs_pkg::WAIT_W'(lo_ff)
                      + wait_prod_ff[rcs_pkg::FRAC_W +: rcs_pkg::WAIT_W];
   assign dur       = (index_ff == total_ff && cut_ff) ? CMP_W'(cut_dur_ff)
                                                       : CMP_W'(ring_on_ff);

   always_comb begin
      phase_in    = phase_ff;
      last_in     = last_ff;
      wait_in     = wait_ff;
      index_in    = index_ff;
      total_in    = total_ff;
      cut_in      = cut_ff;
      relay_in    = relay_ff;
      ring_on_in  = ring_on_ff;
      ring_gap_in = ring_gap_ff;
      case (op_ff)
         rcs_pkg::OP_START: begin
            ring_on_in  = rcs_pkg::DUR_W'(rcs_pkg::RING_ON_DEFAULT);
            ring_gap_in = rcs_pkg::DUR_W'(rcs_pkg::RING_GAP_DEFAULT);
            total_in    = req_ff.given_rings;
            index_in    = rcs_pkg::RINGS_W'(1);
            cut_in      = req_ff.given_cut;
            relay_in    = 1'b1;
            phase_in    = rcs_pkg::PH_RING_ON;
            last_in     = now_t;
         end
         rcs_pkg::OP_STOP: begin
            relay_in = 1'b0;
            phase_in = rcs_pkg::PH_IDLE;
            wait_in  = wait_full;
            last_in  = now_t;
         end
         rcs_pkg::OP_TICK: begin
            case (phase_ff)
               rcs_pkg::PH_RING_ON: begin
                  if (el >= dur) begin
                     relay_in = 1'b0;
                     phase_in = (index_ff >= total_ff) ? rcs_pkg::PH_DONE
                                                       : rcs_pkg::PH_SILENT;
                     last_in  = now_t;
                  end
               end
               rcs_pkg::PH_SILENT: begin
                  if (el >= CMP_W'(ring_gap_ff)) begin
                     index_in = index_ff + rcs_pkg::RINGS_W'(1);
                     relay_in = 1'b1;
                     phase_in = rcs_pkg::PH_RING_ON;
                     last_in  = now_t;
                  end
               end
               rcs_pkg::PH_DONE: begin
                  if (el >= CMP_W'(rcs_pkg::DONE_PAUSE_MS)) begin
                     phase_in = rcs_pkg::PH_WAITING;
                     wait_in  = wait_full;
                     last_in  = now_t;
                  end
               end
               rcs_pkg::PH_WAITING: begin
                  if (el >= CMP_W'(wait_ff)) begin
                     phase_in = rcs_pkg::PH_IDLE;
                     wait_in  = wait_full;
                     last_in  = now_t;
                  end
               end
               default: begin
                  if (el >= CMP_W'(wait_ff)) begin
                     if (req_ff.may_start) begin
                        total_in = req_ff.draw_rings;
                        index_in = rcs_pkg::RINGS_W'(1);
                        cut_in   = req_ff.draw_coin;
                        relay_in = 1'b1;
                        phase_in = rcs_pkg::PH_RING_ON;
                        last_in  = now_t;
                     end else begin
                        wait_in = wait_full >> 2;
                        last_in = now_t;
                     end
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      out_in.relay_on    = relay_in;
      out_in.phase       = phase_in;
      out_in.ringing     = (phase_in == rcs_pkg::PH_RING_ON);
      out_in.busy_res    = (phase_in != rcs_pkg::PH_IDLE) && (phase_in != rcs_pkg::PH_WAITING);
      out_in.ring_number = index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rcs_pkg::PH_IDLE;
         last_ff      <= '0;
         wait_ff      <= '0;
         index_ff     <= '0;
         total_ff     <= '0;
         cut_ff       <= 1'b0;
         relay_ff     <= 1'b0;
         max_delay_ff <= rcs_pkg::DELAY_W'(rcs_pkg::MAX_DELAY_DEFAULT);
         ring_on_ff   <= rcs_pkg::DUR_W'(rcs_pkg::RING_ON_DEFAULT);
         ring_gap_ff  <= rcs_pkg::DUR_W'(rcs_pkg::RING_GAP_DEFAULT);
      end else begin
         if (cmd.commit) begin
            phase_ff    <= phase_in;
            last_ff     <= last_in;
            wait_ff     <= wait_in;
            index_ff    <= index_in;
            total_ff    <= total_in;
            cut_ff      <= cut_in;
            relay_ff    <= relay_in;
            ring_on_ff  <= ring_on_in;
            ring_gap_ff <= ring_gap_in;
         end else if (csr_wr_en) begin
            case (csr_index)
               rcs_pkg::REG_MAX_DELAY: max_delay_ff <= csr_wdata[rcs_pkg::DELAY_W-1:0];
               rcs_pkg::REG_RING_ON:   ring_on_ff   <= csr_wdata[rcs_pkg::DUR_W-1:0];
               rcs_pkg::REG_RING_GAP:  ring_gap_ff  <= csr_wdata[rcs_pkg::DUR_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (csr_index)
         rcs_pkg::REG_MAX_DELAY: csr_rdata = rcs_pkg::CSR_DATA_W'(max_delay_ff);
         rcs_pkg::REG_RING_ON:   csr_rdata = rcs_pkg::CSR_DATA_W'(ring_on_ff);
         rcs_pkg::REG_RING_GAP:  csr_rdata = rcs_pkg::CSR_DATA_W'(ring_gap_ff);
         default:                csr_rdata = '0;
      endcase
   end

   assign rsp_data = out_ff;

endmodule

/* tb/ring_cadence_sequencer_checker.sv */
// Checker for the ring cadence sequencer: predicts each response and compares it.
module ring_cadence_sequencer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [rcs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [rcs_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [rcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rcs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rcs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending,
   output int                             checked,
   output int                             calls_begun
);

   logic [rcs_pkg::DELAY_W-1:0] max_delay_s;
   logic [rcs_pkg::DUR_W-1:0]   ring_on_ms;
   logic [rcs_pkg::DUR_W-1:0]   ring_gap_ms;

   rcs_pkg::phase_type          cad_phase;
   logic [rcs_pkg::NOW_W-1:0]   last_ms;
   logic [31:0]                 wait_ms;
   logic [rcs_pkg::RINGS_W-1:0] ring_idx;
   logic [rcs_pkg::RINGS_W-1:0] ring_cnt;
   logic                        cut_last;
   logic                        relay;

   rcs_pkg::rsp_type            expected_status[$];

   function automatic logic [31:0] scaled_wait(logic [rcs_pkg::FRAC_W-1:0] frac);
      logic [63:0] hi_ms;
      logic [63:0] lo_ms;
      logic [63:0] span;
      hi_ms = 64'(max_delay_s) * 64'(rcs_pkg::MS_PER_S);
      lo_ms = 64'(rcs_pkg::MIN_WAIT_MS);
      if (lo_ms >= hi_ms) begin
         lo_ms = hi_ms / 2;
      end
      span = hi_ms - lo_ms + 64'(1);
      return 32'(lo_ms + ((span * 64'(frac)) >> 16));
   endfunction

   function automatic void begin_call(logic [rcs_pkg::NOW_W-1:0] now,
                                      logic [rcs_pkg::RINGS_W-1:0] rings, logic cut);
      ring_cnt = rings;
      ring_idx = rcs_pkg::RINGS_W'(1);
      cut_last = cut;
      relay = 1'b1;
      cad_phase = rcs_pkg::PH_RING_ON;
      last_ms = now;
      calls_begun++;
   endfunction

   function automatic rcs_pkg::rsp_type step_cadence(logic [1:0] op, rcs_pkg::req_type item);
      rcs_pkg::rsp_type status;
      logic [31:0]      elapsed;
      logic [63:0]      burst_ms;
      elapsed = item.now_ms - last_ms;
      case (op)
         rcs_pkg::OP_START: begin
            ring_on_ms = rcs_pkg::DUR_W'(rcs_pkg::RING_ON_DEFAULT);
            ring_gap_ms = rcs_pkg::DUR_W'(rcs_pkg::RING_GAP_DEFAULT);
            begin_call(item.now_ms, item.given_rings, item.given_cut);
         end
         rcs_pkg::OP_STOP: begin
            relay = 1'b0;
            cad_phase = rcs_pkg::PH_IDLE;
            wait_ms = scaled_wait(item.draw_fraction);
            last_ms = item.now_ms;
         end
         rcs_pkg::OP_TICK: begin
            case (cad_phase)
               rcs_pkg::PH_RING_ON: begin
                  burst_ms = 64'(ring_on_ms);
                  if (ring_idx == ring_cnt && cut_last) begin
                     burst_ms = (burst_ms * 64'(item.draw_percent)) / 100;
                  end
                  if (64'(elapsed) >= burst_ms) begin
                     relay = 1'b0;
                     cad_phase = (ring_idx >= ring_cnt) ? rcs_pkg::PH_DONE
                                                        : rcs_pkg::PH_SILENT;
                     last_ms = item.now_ms;
                  end
               end
               rcs_pkg::PH_SILENT: begin
                  if (elapsed >= 32'(ring_gap_ms)) begin
                     ring_idx = ring_idx + rcs_pkg::RINGS_W'(1);
                     relay = 1'b1;
                     cad_phase = rcs_pkg::PH_RING_ON;
                     last_ms = item.now_ms;
                  end
               end
               rcs_pkg::PH_DONE: begin
                  if (elapsed >= 32'(rcs_pkg::DONE_PAUSE_MS)) begin
                     cad_phase = rcs_pkg::PH_WAITING;
                     wait_ms = scaled_wait(item.draw_fraction);
                     last_ms = item.now_ms;
                  end
               end
               rcs_pkg::PH_WAITING: begin
                  if (elapsed >= wait_ms) begin
                     cad_phase = rcs_pkg::PH_IDLE;
                     wait_ms = scaled_wait(item.draw_fraction);
                     last_ms = item.now_ms;
                  end
               end
               default: begin
                  if (elapsed >= wait_ms) begin
                     if (item.may_start) begin
                        begin_call(item.now_ms, item.draw_rings, item.draw_coin);
                     end else begin
                        wait_ms = scaled_wait(item.draw_fraction) / 4;
                        last_ms = item.now_ms;
                     end
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
      status.relay_on = relay;
      status.phase = cad_phase;
      status.ringing = (cad_phase == rcs_pkg::PH_RING_ON);
      status.busy_res = !(cad_phase == rcs_pkg::PH_IDLE || cad_phase == rcs_pkg::PH_WAITING);
      status.ring_number = ring_idx;
      return status;
   endfunction

   function automatic void note_failure(string what, rcs_pkg::rsp_type want,
                                        rcs_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("checker: %s: expected relay %0b phase %0d ringing %0b busy %0b ring %0d,",
                  what, want.relay_on, want.phase, want.ringing, want.busy_res,
                  want.ring_number);
         $display("checker:    got relay %0b phase %0d ringing %0b busy %0b ring %0d",
                  got.relay_on, got.phase, got.ringing, got.busy_res, got.ring_number);
      end
   endfunction

   always @(posedge clock) begin
      rcs_pkg::rsp_type got;
      rcs_pkg::rsp_type want;
      if (reset) begin
         max_delay_s = rcs_pkg::DELAY_W'(rcs_pkg::MAX_DELAY_DEFAULT);
         ring_on_ms = rcs_pkg::DUR_W'(rcs_pkg::RING_ON_DEFAULT);
         ring_gap_ms = rcs_pkg::DUR_W'(rcs_pkg::RING_GAP_DEFAULT);
         cad_phase = rcs_pkg::PH_IDLE;
         last_ms = '0;
         wait_ms = '0;
         ring_idx = '0;
         ring_cnt = '0;
         cut_last = 1'b0;
         relay = 1'b0;
         expected_status.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               rcs_pkg::REG_MAX_DELAY: max_delay_s = csr_pwdata[rcs_pkg::DELAY_W-1:0];
               rcs_pkg::REG_RING_ON:   ring_on_ms = csr_pwdata[rcs_pkg::DUR_W-1:0];
               rcs_pkg::REG_RING_GAP:  ring_gap_ms = csr_pwdata[rcs_pkg::DUR_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rcs_pkg::rsp_type'(rsp_tdata[$bits(rcs_pkg::rsp_type)-1:0]);
            if (expected_status.size() == 0) begin
               note_failure("response with no request outstanding", got, got);
            end else begin
               want = expected_status.pop_front();
               checked++;
               if (got.relay_on !== want.relay_on || got.phase !== want.phase ||
                   got.ringing !== want.ringing || got.busy_res !== want.busy_res ||
                   got.ring_number !== want.ring_number) begin
                  note_failure($sformatf("response %0d mismatch", checked), want, got);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_status.push_back(step_cadence(req_tuser,
               rcs_pkg::req_type'(req_tdata[$bits(rcs_pkg::req_type)-1:0])));
         end
      end
      pending = expected_status.size();
   end

endmodule

/* tb/tb.sv */
// Top of the ring cadence sequencer testbench: clock, reset, stimulus and verdict.
module tb;

   // Operation code outside the defined set; the block must leave its state alone.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [rcs_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [rcs_pkg::REQ_USER_W-1:0] req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [rcs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [rcs_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rcs_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rcs_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   int                             fail_count;
   int                             pending;
   int                             checked;
   int                             calls_begun;

   int                             send_idle_pct;
   int                             recv_idle_pct;
   int                             rsp_hold;
   int                             sent;
   int                             settings_used;
   logic [rcs_pkg::NOW_W-1:0]      wall_ms;

   ring_cadence_sequencer_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ring_cadence_sequencer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .calls_begun (calls_begun)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: done, errors");
      $finish;
   end

   // The receiver honours a long hold first, otherwise stalls at random.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   function automatic rcs_pkg::req_type make_item(logic [rcs_pkg::NOW_W-1:0] now, logic may,
                                                  logic [rcs_pkg::RINGS_W-1:0] grings,
                                                  logic gcut,
                                                  logic [rcs_pkg::RINGS_W-1:0] drings,
                                                  logic coin,
                                                  logic [rcs_pkg::PCT_W-1:0] pct,
                                                  logic [rcs_pkg::FRAC_W-1:0] frac);
      rcs_pkg::req_type item;
      item.now_ms = now;
      item.may_start = may;
      item.given_rings = grings;
      item.given_cut = gcut;
      item.draw_rings = drings;
      item.draw_coin = coin;
      item.draw_percent = pct;
      item.draw_fraction = frac;
      return item;
   endfunction

   task automatic send_request(logic [1:0] op, rcs_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {{(rcs_pkg::REQ_DATA_W - $bits(rcs_pkg::req_type)){1'b0}}, item};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_random(int step_cap);
      logic [1:0]       op;
      int               pick;
      rcs_pkg::req_type item;
      pick = $urandom_range(0, 99);
      if (pick < 93) begin
         op = rcs_pkg::OP_TICK;
      end else if (pick < 95) begin
         op = rcs_pkg::OP_START;
      end else if (pick < 97) begin
         op = rcs_pkg::OP_STOP;
      end else begin
         op = OP_UNUSED;
      end
      if ($urandom_range(0, 99) < 2) begin
         wall_ms = $urandom();
      end else begin
         wall_ms = wall_ms + rcs_pkg::NOW_W'($urandom_range(0, step_cap));
      end
      item = make_item(wall_ms, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)),
                       ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 4))
                                                  : 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)),
                       ($urandom_range(0, 9) < 8) ? 7'($urandom_range(25, 75))
                                                  : 7'($urandom_range(0, 127)),
                       16'($urandom_range(0, 65535)));
      send_request(op, item);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [rcs_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic configure(int max_delay, int ring_on, int ring_gap);
      write_reg(rcs_pkg::REG_MAX_DELAY, rcs_pkg::CSR_DATA_W'(max_delay));
      write_reg(rcs_pkg::REG_RING_ON, rcs_pkg::CSR_DATA_W'(ring_on));
      write_reg(rcs_pkg::REG_RING_GAP, rcs_pkg::CSR_DATA_W'(ring_gap));
      settings_used++;
   endtask

   // Picks a register setting and returns a time step that suits its cadence.
   task automatic apply_setting(int choice, output int step_cap);
      case (choice)
         0: begin
            configure(rcs_pkg::MAX_DELAY_DEFAULT, rcs_pkg::RING_ON_DEFAULT,
                      rcs_pkg::RING_GAP_DEFAULT);
            step_cap = 3000;
         end
         1: begin configure(0, 0, 0); step_cap = 200; end
         2: begin configure(1, 1, 1); step_cap = 400; end
         3: begin configure(2, 150, 90); step_cap = 600; end
         4: begin configure(3600, 65535, 65535); step_cap = 600000; end
         5: begin configure(4095, 300, 65535); step_cap = 500000; end
         default: begin
            configure($urandom_range(0, 8), $urandom_range(1, 1000), $urandom_range(1, 1000));
            step_cap = 1500;
         end
      endcase
   endtask

   initial begin
      int step_cap;
      int directed;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = rcs_pkg::OP_TICK;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      rsp_hold = 0;
      sent = 0;
      settings_used = 0;
      send_idle_pct = 27;
      recv_idle_pct = 60;
      wall_ms = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed part: odd operation codes, wrap of elapsed time, cut and empty calls.
      send_request(OP_UNUSED, make_item('1, 1, '1, 1, '1, 1, '1, '1));
      send_request(rcs_pkg::OP_TICK, make_item(0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
      send_request(rcs_pkg::OP_TICK, make_item(100, 1, 0, 0, 2, 1, 50, 0));
      send_request(rcs_pkg::OP_STOP, make_item(200, 0, 0, 0, 0, 0, 0, 0));
      send_request(rcs_pkg::OP_TICK, make_item(5200, 1, 0, 0, 2, 1, 50, 0));
      send_request(rcs_pkg::OP_TICK, make_item(7200, 0, 0, 0, 0, 0, 50, 0));
      send_request(rcs_pkg::OP_TICK, make_item(11200, 0, 0, 0, 0, 0, 50, 0));
      send_request(rcs_pkg::OP_TICK, make_item(11200, 0, 0, 0, 0, 0, 0, 0));
      send_request(rcs_pkg::OP_TICK, make_item(12200, 0, 0, 0, 0, 0, 0, 16'hFFFF));
      send_request(rcs_pkg::OP_TICK, make_item(32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0, 16'h8000));
      send_request(rcs_pkg::OP_START, make_item(32'hFFFF_FFFF, 0, 0, 1, 0, 0, 0, 0));
      send_request(rcs_pkg::OP_TICK, make_item(5, 0, 0, 0, 0, 0, 127, 0));
      send_request(rcs_pkg::OP_TICK, make_item(2000, 0, 0, 0, 0, 0, 127, 0));
      send_request(rcs_pkg::OP_START, make_item(2100, 0, 15, 0, 15, 1, 0, 0));
      send_request(rcs_pkg::OP_TICK, make_item(4100, 0, 0, 0, 0, 0, 0, 0));
      send_request(rcs_pkg::OP_STOP, make_item(4101, 1, 0, 0, 0, 0, 0, 16'h8000));
      send_request(OP_UNUSED, make_item(0, 0, 0, 0, 0, 0, 0, 0));
      drain();
      configure(0, 0, 65535);
      send_request(rcs_pkg::OP_STOP, make_item(50, 0, 0, 0, 0, 0, 0, 16'hFFFF));
      send_request(rcs_pkg::OP_TICK, make_item(50, 1, 0, 0, 0, 0, 60, 0));
      send_request(rcs_pkg::OP_TICK, make_item(50, 0, 0, 0, 0, 0, 60, 0));
      send_request(rcs_pkg::OP_TICK, make_item(1050, 0, 0, 0, 0, 0, 0, 16'hFFFF));
      send_request(rcs_pkg::OP_TICK, make_item(1050, 0, 0, 0, 0, 0, 0, 16'hFFFF));
      send_request(rcs_pkg::OP_TICK, make_item(1050, 0, 0, 0, 0, 0, 0, 16'hFFFF));
      directed = sent;
      drain();

      // Random part: three idling profiles, each run under several register settings.
      for (int profile = 0; profile < 3; profile++) begin
         send_idle_pct = (profile == 0) ? 27 : (profile == 1) ? 60 : 0;
         recv_idle_pct = (profile == 0) ? 60 : (profile == 1) ? 27 : 0;
         for (int k = 0; k < 6; k++) begin
            drain();
            apply_setting((profile * 6 + k) % 7, step_cap);
            wall_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535)
                                                  : $urandom();
            if (profile == 2 && k == 1) begin
               rsp_hold = 300;
            end
            repeat (75) send_random(step_cap);
         end
      end
      drain();

      $display("tb summary: %0d requests (%0d directed) under %0d register settings,",
               sent, directed, settings_used);
      $display("tb summary: %0d responses checked, %0d calls begun", checked, calls_begun);
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/rcs_pkg.sv
rtl/rcs_ctrl.sv
rtl/rcs_datapath.sv
rtl/ring_cadence_sequencer_top.sv
tb/ring_cadence_sequencer_checker.sv
tb/tb.sv
